### design/efq_pkg.sv
`timescale 1ns / 1ps
package efq_pkg;

  // Fixed widths of the word fields.
  localparam int ACTION_W = 2;
  localparam int CODE_W   = 5;
  localparam int SUB_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REGISTER = 2'd0,
    ACT_SEND     = 2'd1,
    ACT_RECEIVE  = 2'd2,
    ACT_NOP      = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SLOT  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SLOT_RD,
    S_SLOT_PUSH,
    S_POP_RD,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic reg_write;
    logic slot_read;
    logic slot_push;
    logic pop_read;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    walk_more;
    logic    last_slot;
    logic    can_pop;
    logic    out_free;
  } dp_sts_t;

endpackage

### design/efq_req_if.sv
`timescale 1ns / 1ps
interface efq_req_if import efq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CODE_W-1:0]   event_code;
  logic [SUB_W-1:0]    subscriber;

  modport source (output valid, output action, output event_code, output subscriber,
                  input ready);
  modport sink (input valid, input action, input event_code, input subscriber,
                output ready);
endinterface

### design/efq_rsp_if.sv
`timescale 1ns / 1ps
interface efq_rsp_if import efq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CODE_W-1:0]   event_out;
  logic [COUNT_W-1:0]  delivered;

  modport source (output valid, output status, output event_out, output delivered,
                  input ready);
  modport sink (input valid, input status, input event_out, input delivered,
                output ready);
endinterface

### design/event_fanout_queues_core.sv
`timescale 1ns / 1ps
// Publish-subscribe event router. Each request word is a register, send,
// receive or no-op action and yields exactly one response word. A register
// goes from S_EXEC to S_FINISH, a receive passes through S_POP_RD when the
// subscriber queue holds an event, and a send walks the filled subscription
// slots of the event, where each slot costs one owner table read (S_SLOT_RD)
// followed by one queue write (S_SLOT_PUSH). A full subscriber queue drops the
// event for that subscriber only and the send reports overflow. The core works
// on one word at a time; a finished response sits in an output register and is
// held until taken. No clearing pass is needed after reset.
module event_fanout_queues_core import efq_pkg::*; #(
  parameter int NUM_EVENTS      = 32,
  parameter int SLOTS_PER_EVENT = 4,
  parameter int QUEUE_DEPTH     = 16,
  parameter int NUM_SUBSCRIBERS = 8
) (
  input  logic      clk,
  input  logic      rst,
  efq_req_if.sink   req,
  efq_rsp_if.source rsp
);

  cmd_t    cmd;
  dp_sts_t sts;
  logic    req_ready;

  assign req.ready = req_ready;

  // Sequencer.
  efq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tables, queues and response register.
  efq_dp #(
    .NUM_EVENTS      (NUM_EVENTS),
    .SLOTS_PER_EVENT (SLOTS_PER_EVENT),
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .NUM_SUBSCRIBERS (NUM_SUBSCRIBERS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .req_action (req.action),
    .req_code   (req.event_code),
    .req_sub    (req.subscriber),
    .cmd        (cmd),
    .sts        (sts),
    .rsp        (rsp)
  );

endmodule

### design/efq_ctrl.sv
`timescale 1ns / 1ps
module efq_ctrl import efq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  dp_sts_t sts,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (sts.action)
          ACT_SEND:    state_next = sts.walk_more ? S_SLOT_RD : S_FINISH;
          ACT_RECEIVE: state_next = sts.can_pop ? S_POP_RD : S_FINISH;
          default:     state_next = S_FINISH;
        endcase
      end
      S_SLOT_RD:   state_next = S_SLOT_PUSH;
      S_SLOT_PUSH: state_next = sts.last_slot ? S_FINISH : S_SLOT_RD;
      S_POP_RD:    state_next = S_FINISH;
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_EXEC: begin
        cmd.reg_write = (sts.action == ACT_REGISTER);
      end
      S_SLOT_RD:   cmd.slot_read = 1'b1;
      S_SLOT_PUSH: cmd.slot_push = 1'b1;
      S_POP_RD:    cmd.pop_read = 1'b1;
      S_FINISH:    cmd.emit = sts.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

### design/efq_dp.sv
`timescale 1ns / 1ps
module efq_dp import efq_pkg::*; #(
  parameter int NUM_EVENTS      = 32,
  parameter int SLOTS_PER_EVENT = 4,
  parameter int QUEUE_DEPTH     = 16,
  parameter int NUM_SUBSCRIBERS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ACTION_W-1:0] req_action,
  input  logic [CODE_W-1:0]   req_code,
  input  logic [SUB_W-1:0]    req_sub,
  input  cmd_t                cmd,
  output dp_sts_t             sts,
  efq_rsp_if.source           rsp
);

  // Only codes and subscribers that the word fields can name get storage.
  localparam int EV_USED  = (NUM_EVENTS < (1 << CODE_W)) ? NUM_EVENTS : (1 << CODE_W);
  localparam int SUB_USED = (NUM_SUBSCRIBERS < (1 << SUB_W)) ? NUM_SUBSCRIBERS : (1 << SUB_W);
  localparam int EW       = (EV_USED > 1) ? $clog2(EV_USED) : 1;
  localparam int SW       = (SUB_USED > 1) ? $clog2(SUB_USED) : 1;
  localparam int CW       = $clog2(SLOTS_PER_EVENT + 1);
  localparam int IW       = (SLOTS_PER_EVENT > 1) ? $clog2(SLOTS_PER_EVENT) : 1;
  localparam int SLOT_CNT = EV_USED * SLOTS_PER_EVENT;
  localparam int SAW      = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;
  localparam int PW       = $clog2(QUEUE_DEPTH);
  localparam int QENT     = SUB_USED * QUEUE_DEPTH;
  localparam int QAW      = (QENT > 1) ? $clog2(QENT) : 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Latched word and walk state.
  action_t            act_q;
  logic [CODE_W-1:0]  code_q;
  logic [SUB_W-1:0]   sub_q;
  logic [CW-1:0]      idx;
  logic [SW-1:0]      owner_q;
  logic [CODE_W-1:0]  qdata;
  logic               popped;
  status_t            status_q;
  logic [COUNT_W-1:0] deliv_q;

  // Subscription fill counts and queue pointers.
  logic [CW-1:0] fill [EV_USED];
  logic [PW-1:0] rp   [SUB_USED];
  logic [PW-1:0] wp   [SUB_USED];

  // Owner table and queue storage.
  logic [SW-1:0]     owner_mem [SLOT_CNT];
  logic [CODE_W-1:0] queue_mem [QENT];

  // Result register.
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [CODE_W-1:0]   out_event;
  logic [COUNT_W-1:0]  out_deliv;

  logic          code_ok;
  logic          sub_ok;
  logic [EW-1:0] ev_idx;
  logic [SW-1:0] sb_idx;
  logic [CW-1:0] fill_cur;
  logic          room;
  logic [PW-1:0] wp_own;
  logic          full;
  logic          out_free;

  function automatic logic [SAW-1:0] slot_addr(input logic [EW-1:0] e,
                                               input logic [IW-1:0] i);
    slot_addr = SAW'(e) * SAW'(SLOTS_PER_EVENT) + SAW'(i);
  endfunction

  function automatic logic [QAW-1:0] queue_addr(input logic [SW-1:0] s,
                                                input logic [PW-1:0] p);
    queue_addr = QAW'(s) * QAW'(QUEUE_DEPTH) + QAW'(p);
  endfunction

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = ((32'(p) + 1) >= QUEUE_DEPTH) ? '0 : p + PW'(1);
  endfunction

  // Decode of the latched word.
  assign code_ok  = 32'(code_q) < NUM_EVENTS;
  assign sub_ok   = 32'(sub_q) < NUM_SUBSCRIBERS;
  assign ev_idx   = code_q[EW-1:0];
  assign sb_idx   = sub_q[SW-1:0];
  assign fill_cur = fill[ev_idx];
  assign room     = code_ok && sub_ok && (fill_cur < CW'(SLOTS_PER_EVENT));
  assign wp_own   = wp[owner_q];
  assign full     = ring_next(wp_own) == rp[owner_q];
  assign out_free = !out_valid || rsp.ready;

  // Status toward the controller.
  assign sts.action    = act_q;
  assign sts.walk_more = code_ok && (idx < fill_cur);
  assign sts.last_slot = (idx + CW'(1)) == fill_cur;
  assign sts.can_pop   = sub_ok && (rp[sb_idx] != wp[sb_idx]);
  assign sts.out_free  = out_free;

  // Fill counts, pointers and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int e = 0; e < EV_USED; e++) begin
        fill[e] <= '0;
      end
      for (int s = 0; s < SUB_USED; s++) begin
        rp[s] <= '0;
        wp[s] <= '0;
      end
    end else begin
      if (cmd.reg_write && room) fill[ev_idx] <= fill_cur + CW'(1);
      if (cmd.slot_push && !full) wp[owner_q] <= ring_next(wp_own);
      if (cmd.pop_read) rp[sb_idx] <= ring_next(rp[sb_idx]);
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Word capture and result accumulation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= action_t'(req_action);
      code_q  <= req_code;
      sub_q   <= req_sub;
      idx     <= '0;
      deliv_q <= '0;
      popped  <= 1'b0;
      case (action_t'(req_action))
        ACT_REGISTER: status_q <= STAT_NO_SLOT;
        ACT_RECEIVE:  status_q <= STAT_EMPTY;
        default:      status_q <= STAT_OK;
      endcase
    end
    if (cmd.reg_write && room) status_q <= STAT_OK;
    if (cmd.slot_push) begin
      idx <= idx + CW'(1);
      if (full) begin
        status_q <= STAT_OVERFLOW;
      end else if (deliv_q != COUNT_MAX) begin
        deliv_q <= deliv_q + COUNT_W'(1);
      end
    end
    if (cmd.pop_read) begin
      popped   <= 1'b1;
      status_q <= STAT_OK;
    end
    if (cmd.emit) begin
      out_status <= status_q;
      out_event  <= popped ? qdata : '0;
      out_deliv  <= deliv_q;
    end
  end

  // Owner table: written on register, read once per walked slot.
  always_ff @(posedge clk) begin
    if (cmd.reg_write && room) owner_mem[slot_addr(ev_idx, fill_cur[IW-1:0])] <= sb_idx;
    if (cmd.slot_read) owner_q <= owner_mem[slot_addr(ev_idx, idx[IW-1:0])];
  end

  // Queue storage: written on a push that fits, read on a pop.
  always_ff @(posedge clk) begin
    if (cmd.slot_push && !full) queue_mem[queue_addr(owner_q, wp_own)] <= code_q;
    if (cmd.pop_read) qdata <= queue_mem[queue_addr(sb_idx, rp[sb_idx])];
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.event_out = out_event;
  assign rsp.delivered = out_deliv;

endmodule
